[rtl/core/plru_pkg.sv]
// Package: types and constants shared by the pinned LRU entry cache.
package plru_pkg;

  localparam int unsigned NUM_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(NUM_ENTRIES);
  localparam int unsigned PTR_W       = IDX_W + 1;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned CFG_W       = 11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Empty marker: the index one past the table.
  localparam ptr_t NO_ENTRY = ptr_t'(NUM_ENTRIES);

  typedef enum logic [1:0] {
    OP_VISIT = 2'd0,
    OP_PASS  = 2'd1,
    OP_EVICT = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic {
    CFG_HIGH_WM = 1'b0,
    CFG_LOW_WM  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] operation;
    idx_t       entry_index;
    logic       visible;
    logic       clip_stale;
  } in_item_t;

  typedef struct packed {
    logic load_request;
    idx_t load_index;
    logic evicted;
    idx_t evicted_index;
    logic eviction_done;
    cnt_t cached_count;
  } out_item_t;

  // Word of the entry memory: flags and the link toward the older end.
  typedef struct packed {
    logic cached;
    logic pinned;
    ptr_t next;
  } entry_t;

  function automatic logic ptr_valid(ptr_t p);
    return p < NO_ENTRY;
  endfunction

endpackage

[rtl/core/pinned_lru_entry_cache.sv]
// Top level: pinned LRU residency manager built around an entry memory and a prev-link memory.
//
// Usage: pulse start_i with an item while busy_o is low. Exactly one result
// comes back per item on result_o, marked by result_valid_o for one cycle;
// the receiver cannot stall it, so capture it when the strobe is high.
// Steps: end of pass, clear and an unarmed or finished evict step answer
// from idle; a visit reads the entry, and an invisible one ends there; a
// visible visit pushes the entry at the head and links it, after one extra
// read-modify-write of the newer neighbor's link word when the entry is
// already cached and has a newer neighbor.
// An evict step reads one entry per pinned entry skipped toward the head,
// then drops the first unpinned one, plus a read-modify-write of its newer
// neighbor's link word when it has one, or runs out of unpinned entries.
// The entry and prev-link memories have registered reads and one write port
// each. After reset and after a clear the entry memory is swept, one entry a
// cycle (all 1024 entries), with busy_o high; config writes still land.
module pinned_lru_entry_cache (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  plru_pkg::in_item_t    in_item_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output plru_pkg::out_item_t   result_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [plru_pkg::CFG_W-1:0] cfg_wdata_i
);
  import plru_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_V_RD, ST_V_FIX, ST_V_PUSH, ST_V_LINK, ST_E_RD, ST_E_FIX, ST_CLR
  } state_e;

  state_e    state_q, state_d;
  idx_t      idx_q, idx_d;
  logic      vis_q, vis_d, stale_q, stale_d, load_q, load_d;
  ptr_t      n_q, n_d, p_q, p_d;
  ptr_t      head_q, head_d, tail_q, tail_d, cursor_q, cursor_d;
  cnt_t      cnt_q, cnt_d;
  logic      armed_q, armed_d;
  logic [CFG_W-1:0] hi_q, hi_d, lo_q, lo_d;
  idx_t      clr_q, clr_d;
  logic      valid_q, valid_d;
  out_item_t out_q, out_d;

  // entry memory {cached, pinned, next} and prev-link memory
  entry_t mem_a [NUM_ENTRIES];
  ptr_t   mem_b [NUM_ENTRIES];
  logic   a_we, b_we;
  idx_t   a_waddr, a_raddr, b_waddr, b_raddr;
  entry_t a_wdata, a_rdata_q;
  ptr_t   b_wdata, b_rdata_q;
  cnt_t   cnt_dec;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[a_waddr] <= a_wdata;
    end
    a_rdata_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mem_b[b_waddr] <= b_wdata;
    end
    b_rdata_q <= mem_b[b_raddr];
  end

  assign cnt_dec = cnt_q - cnt_t'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    vis_d    = vis_q;
    stale_d  = stale_q;
    load_d   = load_q;
    n_d      = n_q;
    p_d      = p_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cursor_d = cursor_q;
    cnt_d    = cnt_q;
    armed_d  = armed_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    clr_d    = clr_q;
    valid_d  = 1'b0;
    out_d    = '0;
    a_we     = 1'b0;
    b_we     = 1'b0;
    a_waddr  = idx_q;
    a_wdata  = '0;
    b_waddr  = idx_q;
    b_wdata  = NO_ENTRY;
    a_raddr  = idx_q;
    b_raddr  = idx_q;

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HIGH_WM: hi_d = cfg_wdata_i;
        CFG_LOW_WM:  lo_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op_e'(in_item_i.operation))
            OP_VISIT: begin
              // a visit cancels any eviction in flight
              armed_d  = 1'b0;
              cursor_d = NO_ENTRY;
              idx_d    = in_item_i.entry_index;
              vis_d    = in_item_i.visible;
              stale_d  = in_item_i.clip_stale;
              a_raddr  = in_item_i.entry_index;
              b_raddr  = in_item_i.entry_index;
              state_d  = ST_V_RD;
            end
            OP_PASS: begin
              if (cnt_q > cnt_t'(hi_q)) begin
                armed_d  = 1'b1;
                cursor_d = tail_q;
              end else begin
                armed_d  = 1'b0;
                cursor_d = NO_ENTRY;
              end
              valid_d = 1'b1;
            end
            OP_EVICT: begin
              if (!armed_q) begin
                valid_d = 1'b1;
              end else if (cnt_q <= cnt_t'(lo_q) || !ptr_valid(cursor_q)) begin
                armed_d  = 1'b0;
                cursor_d = NO_ENTRY;
                valid_d  = 1'b1;
              end else begin
                idx_d   = cursor_q[IDX_W-1:0];
                a_raddr = cursor_q[IDX_W-1:0];
                b_raddr = cursor_q[IDX_W-1:0];
                state_d = ST_E_RD;
              end
            end
            OP_CLEAR: begin
              head_d   = NO_ENTRY;
              tail_d   = NO_ENTRY;
              cursor_d = NO_ENTRY;
              cnt_d    = '0;
              armed_d  = 1'b0;
              clr_d    = '0;
              valid_d  = 1'b1;
              state_d  = ST_CLR;
            end
            default: ;
          endcase
        end
      end

      ST_V_RD: begin
        if (!vis_q) begin
          a_we    = 1'b1;
          a_wdata = '{cached: a_rdata_q.cached, pinned: 1'b0, next: a_rdata_q.next};
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else if (!a_rdata_q.cached) begin
          load_d  = 1'b1;
          cnt_d   = cnt_q + cnt_t'(1);
          state_d = ST_V_PUSH;
        end else begin
          // unlink: patch the older neighbor here, the newer one next cycle
          load_d = stale_q;
          n_d    = a_rdata_q.next;
          p_d    = b_rdata_q;
          if (ptr_valid(a_rdata_q.next)) begin
            b_we    = 1'b1;
            b_waddr = a_rdata_q.next[IDX_W-1:0];
            b_wdata = b_rdata_q;
          end else begin
            tail_d = b_rdata_q;
          end
          if (ptr_valid(b_rdata_q)) begin
            a_raddr = b_rdata_q[IDX_W-1:0];
            state_d = ST_V_FIX;
          end else begin
            head_d  = a_rdata_q.next;
            state_d = ST_V_PUSH;
          end
        end
      end

      ST_V_FIX: begin
        a_we    = 1'b1;
        a_waddr = p_q[IDX_W-1:0];
        a_wdata = '{cached: a_rdata_q.cached, pinned: a_rdata_q.pinned, next: n_q};
        state_d = ST_V_PUSH;
      end

      ST_V_PUSH: begin
        a_we    = 1'b1;
        a_wdata = '{cached: 1'b1, pinned: 1'b1, next: head_q};
        b_we    = 1'b1;
        b_wdata = NO_ENTRY;
        state_d = ST_V_LINK;
      end

      ST_V_LINK: begin
        if (ptr_valid(head_q)) begin
          b_we    = 1'b1;
          b_waddr = head_q[IDX_W-1:0];
          b_wdata = ptr_t'(idx_q);
        end else begin
          tail_d = ptr_t'(idx_q);
        end
        head_d             = ptr_t'(idx_q);
        out_d.load_request = load_q;
        out_d.load_index   = load_q ? idx_q : '0;
        load_d             = 1'b0;
        valid_d            = 1'b1;
        state_d            = ST_IDLE;
      end

      ST_E_RD: begin
        if (a_rdata_q.pinned) begin
          // skip a pinned entry, walking toward the head
          if (ptr_valid(b_rdata_q)) begin
            idx_d   = b_rdata_q[IDX_W-1:0];
            a_raddr = b_rdata_q[IDX_W-1:0];
            b_raddr = b_rdata_q[IDX_W-1:0];
          end else begin
            armed_d  = 1'b0;
            cursor_d = NO_ENTRY;
            valid_d  = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          a_we    = 1'b1;
          a_wdata = '{cached: 1'b0, pinned: 1'b0, next: a_rdata_q.next};
          n_d     = a_rdata_q.next;
          p_d     = b_rdata_q;
          if (ptr_valid(a_rdata_q.next)) begin
            b_we    = 1'b1;
            b_waddr = a_rdata_q.next[IDX_W-1:0];
            b_wdata = b_rdata_q;
          end else begin
            tail_d = b_rdata_q;
          end
          cnt_d    = cnt_dec;
          armed_d  = !(cnt_dec <= cnt_t'(lo_q) || !ptr_valid(b_rdata_q));
          cursor_d = armed_d ? b_rdata_q : NO_ENTRY;
          out_d.evicted       = 1'b1;
          out_d.evicted_index = idx_q;
          if (ptr_valid(b_rdata_q)) begin
            a_raddr = b_rdata_q[IDX_W-1:0];
            state_d = ST_E_FIX;
          end else begin
            head_d  = a_rdata_q.next;
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_E_FIX: begin
        a_we                = 1'b1;
        a_waddr             = p_q[IDX_W-1:0];
        a_wdata             = '{cached: a_rdata_q.cached, pinned: a_rdata_q.pinned, next: n_q};
        out_d.evicted       = 1'b1;
        out_d.evicted_index = idx_q;
        valid_d             = 1'b1;
        state_d             = ST_IDLE;
      end

      ST_CLR: begin
        a_we    = 1'b1;
        a_waddr = clr_q;
        a_wdata = '0;
        clr_d   = clr_q + idx_t'(1);
        if (clr_q == idx_t'(NUM_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    out_d.eviction_done = !armed_d;
    out_d.cached_count  = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      head_q   <= NO_ENTRY;
      tail_q   <= NO_ENTRY;
      cursor_q <= NO_ENTRY;
      cnt_q    <= '0;
      armed_q  <= 1'b0;
      hi_q     <= CFG_W'(256);
      lo_q     <= CFG_W'(192);
      valid_q  <= 1'b0;
      load_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cursor_q <= cursor_d;
      cnt_q    <= cnt_d;
      armed_q  <= armed_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      valid_q  <= valid_d;
      load_q   <= load_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    vis_q   <= vis_d;
    stale_q <= stale_d;
    n_q     <= n_d;
    p_q     <= p_d;
    out_q   <= out_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = out_q;

endmodule
